FILE: sv/sid_pkg.sv
// ----------------------------------------------------------------------------
// sid_pkg: shared types for the signed integer divider
// Sequencer state codes and the control group from sequencer to datapath.
// ----------------------------------------------------------------------------
package sid_pkg;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    typedef struct packed {
        logic load;    // capture operands and magnitudes
        logic step;    // retire one quotient bit
        logic finish;  // apply sign and special cases, register result
    } ctrl_t;

endpackage

FILE: sv/sid_seq.sv
// ----------------------------------------------------------------------------
// sid_seq: divider sequencer
// Walks idle, one step per quotient bit, and a finish state.
// ----------------------------------------------------------------------------
module sid_seq #(
    parameter int DATA_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output logic           done,
    output sid_pkg::ctrl_t ctrl
);

    localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

    sid_pkg::state_t state_reg;
    sid_pkg::state_t state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             done_reg;
    logic             done_next;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        ctrl.load   = 1'b0;
        ctrl.step   = 1'b0;
        ctrl.finish = 1'b0;
        unique case (state_reg)
            sid_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    cnt_next   = '0;
                    state_next = sid_pkg::ST_RUN;
                end
            end
            sid_pkg::ST_RUN:
            begin
                ctrl.step = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = sid_pkg::ST_FIN;
                end
            end
            sid_pkg::ST_FIN:
            begin
                ctrl.finish = 1'b1;
                done_next   = 1'b1;
                state_next  = sid_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sid_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sid_pkg::ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != sid_pkg::ST_IDLE);
    assign done = done_reg;

endmodule

FILE: sv/sid_datapath.sv
// ----------------------------------------------------------------------------
// sid_datapath: shift-subtract divider datapath
// Magnitude capture, one shared subtract/compare per step, sign fix-up and special cases.
// ----------------------------------------------------------------------------
module sid_datapath #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  sid_pkg::ctrl_t               ctrl,
    input  logic signed [DATA_WIDTH-1:0] numerator,
    input  logic signed [DATA_WIDTH-1:0] denominator,
    output logic signed [DATA_WIDTH-1:0] quotient,
    output logic                         overflow,
    output logic                         zero_divisor
);

    localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] ALL_ONES = {DATA_WIDTH{1'b1}};

    logic [DATA_WIDTH-1:0] num_u;
    logic [DATA_WIDTH-1:0] den_u;
    logic [DATA_WIDTH-1:0] num_mag;
    logic [DATA_WIDTH-1:0] den_mag;

    // a_reg holds the dividend bits still to enter and collects quotient bits
    logic [DATA_WIDTH-1:0] a_reg;
    logic [DATA_WIDTH-1:0] a_next;
    logic [DATA_WIDTH-1:0] b_reg;
    logic [DATA_WIDTH-1:0] b_next;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] rem_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic                  zdiv_reg;
    logic                  zdiv_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [DATA_WIDTH-1:0] quo_next;
    logic                  ovf_out_reg;
    logic                  ovf_out_next;
    logic                  zdiv_out_reg;
    logic                  zdiv_out_next;

    logic [DATA_WIDTH-1:0] rem_shift;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;

    assign num_u   = numerator;
    assign den_u   = denominator;
    assign num_mag = num_u[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - num_u) : num_u;
    assign den_mag = den_u[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - den_u) : den_u;

    // For a nonzero divisor the remainder stays below it, so the shifted value fits the width
    assign rem_shift = {rem_reg[DATA_WIDTH-2:0], a_reg[DATA_WIDTH-1]};
    assign diff      = {1'b0, rem_shift} - {1'b0, b_reg};
    assign fits      = !diff[DATA_WIDTH];

    always_comb
    begin
        a_next        = a_reg;
        b_next        = b_reg;
        rem_next      = rem_reg;
        neg_next      = neg_reg;
        zdiv_next     = zdiv_reg;
        ovf_next      = ovf_reg;
        quo_next      = quo_reg;
        ovf_out_next  = ovf_out_reg;
        zdiv_out_next = zdiv_out_reg;
        if (ctrl.load)
        begin
            a_next    = num_mag;
            b_next    = den_mag;
            rem_next  = '0;
            neg_next  = num_u[DATA_WIDTH-1] ^ den_u[DATA_WIDTH-1];
            zdiv_next = (den_u == '0);
            ovf_next  = (num_u == MOST_NEG) && (den_u == ALL_ONES);
        end
        if (ctrl.step)
        begin
            a_next   = {a_reg[DATA_WIDTH-2:0], fits};
            rem_next = fits ? diff[DATA_WIDTH-1:0] : rem_shift;
        end
        if (ctrl.finish)
        begin
            priority if (zdiv_reg)
            begin
                quo_next = '0;
            end
            else if (ovf_reg)
            begin
                quo_next = MOST_POS;
            end
            else if (neg_reg)
            begin
                quo_next = DATA_WIDTH'(0) - a_reg;
            end
            else
            begin
                quo_next = a_reg;
            end
            ovf_out_next  = ovf_reg && !zdiv_reg;
            zdiv_out_next = zdiv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        zdiv_reg     <= zdiv_next;
        ovf_reg      <= ovf_next;
        quo_reg      <= quo_next;
        ovf_out_reg  <= ovf_out_next;
        zdiv_out_reg <= zdiv_out_next;
    end

    assign quotient     = quo_reg;
    assign overflow     = ovf_out_reg;
    assign zero_divisor = zdiv_out_reg;

endmodule

FILE: sv/signed_integer_divider.sv
// ----------------------------------------------------------------------------
// signed_integer_divider: signed division truncating toward zero
// Restoring shift-subtract division on magnitudes, one quotient bit a cycle.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+-------------------
//   request  | numerator, denominator                  | start && !busy
//   result   | quotient, overflow, zero_divisor        | done, one cycle
//
// A request passes from acceptance to done through one load, DATA_WIDTH
// steps of the shared subtract/compare unit and one finish step.
// busy stays high from the cycle after acceptance until done rises; a new
// request may be taken in the cycle done is high.
// Reset clears the sequencer only; results cannot be stalled.
// ----------------------------------------------------------------------------
module signed_integer_divider #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] numerator,
    input  logic signed [DATA_WIDTH-1:0] denominator,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] quotient,
    output logic                         overflow,
    output logic                         zero_divisor
);

    sid_pkg::ctrl_t ctrl;

    sid_seq #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctrl  (ctrl)
    );

    sid_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .ctrl         (ctrl),
        .numerator    (numerator),
        .denominator  (denominator),
        .quotient     (quotient),
        .overflow     (overflow),
        .zero_divisor (zero_divisor)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a request in flight");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(overflow && zero_divisor))
        else $error("overflow and zero divisor both set");

    a_zero_div_quot: assert property (@(posedge clk) disable iff (!rst_n)
        done && zero_divisor |-> quotient == '0)
        else $error("nonzero quotient on zero divisor");

endmodule
